>>> rtl/ddbf_pkg.sv
package ddbf_pkg;

  // depth/density profile
  localparam int PROF_N = 10;
  localparam int PROF_IW = $clog2(PROF_N);
  localparam int PROF_DEPTH [PROF_N] = '{0, 500, 1000, 1600, 2400, 3600, 5000, 9000, 11000,
                                         15000};
  localparam int PROF_RHO [PROF_N] = '{2200, 2450, 2550, 2600, 2600, 2620, 2650, 2720, 2750,
                                       2900};

  // datapath widths
  localparam int NUM_W  = 46;
  localparam int DEN_W  = 24;
  localparam int QUO_W  = 21;
  localparam int DIFF_W = 24;
  localparam int RES_W  = 52;

  // config register indexes
  localparam logic [2:0] REG_FLUID_DENSITY  = 3'd0;
  localparam logic [2:0] REG_GRAVITY        = 3'd1;
  localparam logic [2:0] REG_OVERPRESSURE   = 3'd2;
  localparam logic [2:0] REG_TRANS_START    = 3'd3;
  localparam logic [2:0] REG_TRANS_END      = 3'd4;
  localparam logic [2:0] REG_REF_DENSITY    = 3'd5;

  // per-request data that rides alongside the divider
  typedef struct packed {
    logic        valid;
    logic signed [15:0] t;
    logic        invalid;
    logic [15:0] rock_base;
    logic        rock_neg;
    logic [19:0] pf_base;
    logic        trans_neg;
  } side_t;

endpackage

>>> rtl/ddbf_div.sv
module ddbf_div #(
  parameter int NW = 46,
  parameter int DW = 24,
  parameter int QW = 21,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic [NW-1:0] rem_s  [QW];
  logic [DW-1:0] den_s  [QW];
  logic [QW-1:0] quo_s  [QW];
  logic [SW-1:0] side_s [QW];
  logic          vld_s  [QW];

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_k;
    logic          vld_in;
    logic [NW-1:0] sh;
    logic          ge;

    // stage input: module ports for the first stage, previous stage otherwise
    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
      assign side_k = side_in;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_s[k-1];
      assign den_in = den_s[k-1];
      assign quo_in = quo_s[k-1];
      assign side_k = side_s[k-1];
      assign vld_in = vld_s[k-1];
    end

    assign sh = {{(NW-DW){1'b0}}, den_in} << (QW-1-k);
    assign ge = rem_in >= sh;

    always_ff @(posedge clk) begin
      rem_s[k]  <= ge ? rem_in - sh : rem_in;
      den_s[k]  <= den_in;
      quo_s[k]  <= {quo_in[QW-2:0], ge};
      side_s[k] <= side_k;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k] <= 1'b0;
      end else begin
        vld_s[k] <= vld_in;
      end
    end
  end

  assign out_valid = vld_s[QW-1];
  assign quo       = quo_s[QW-1];
  assign side_out  = side_s[QW-1];

endmodule

>>> rtl/depth_density_body_force_residual_unit.sv
// Depth-dependent effective body force residual, one quadrature point per request.
// Requests: raise start with z_coordinate and test_value; a request is taken at any
// rising edge where start is high and busy is low. busy stays low, so a new request
// may be taken in every cycle.
// Results: residual and config_invalid are shown for exactly one cycle with done high;
// results leave in request order. The pipeline is the restoring divider (one
// quotient bit per stage, 21 stages) plus five stages in front of it (input, depth,
// lookup, products, rounding) and four behind it (difference, multiplies and
// saturation); the input stage loads on the accepting edge. Throughput is one
// request per cycle.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 fluid density,
// 1 gravity, 2 overpressure enable, 3 transition start, 4 transition end,
// 5 reference density); other indexes are ignored. Write only while no request
// is in flight.
// Reset: synchronous rst clears all in-flight requests and loads the default
// register values. The receiver cannot stall; results are never held.
module depth_density_body_force_residual_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] z_coordinate,
  input  logic signed [15:0] test_value,
  output logic               done,
  output logic signed [51:0] residual,
  output logic               config_invalid,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import ddbf_pkg::*;

  // configuration registers
  logic [15:0] fluid_rho;
  logic [15:0] gravity;
  logic        overpressure_enable;
  logic [23:0] transition_start_depth;
  logic [23:0] transition_end_depth;
  logic [15:0] reference_density;

  always_ff @(posedge clk) begin
    if (rst) begin
      fluid_rho              <= 16'd1000;
      gravity                <= 16'd40141;
      overpressure_enable    <= 1'b0;
      transition_start_depth <= '0;
      transition_end_depth   <= '0;
      reference_density      <= 16'd2900;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLUID_DENSITY: fluid_rho              <= cfg_data[15:0];
        REG_GRAVITY:       gravity                <= cfg_data[15:0];
        REG_OVERPRESSURE:  overpressure_enable    <= cfg_data[0];
        REG_TRANS_START:   transition_start_depth <= cfg_data;
        REG_TRANS_END:     transition_end_depth   <= cfg_data;
        REG_REF_DENSITY:   reference_density      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: input register
  logic               v1;
  logic signed [23:0] z1;
  logic signed [15:0] t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    z1 <= z_coordinate;
    t1 <= test_value;
  end

  // stage 2: depth as absolute value
  logic               v2;
  logic [23:0]        d2;
  logic signed [15:0] t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    d2 <= z1[23] ? 24'(-z1) : 24'(z1);
    t2 <= t1;
  end

  // stage 3: segment lookup and pore-pressure region
  logic [PROF_IW-1:0] seg;
  logic               deep;
  logic [23:0]        seg_lo;
  logic signed [15:0] seg_drho;
  logic [19:0]        fl16;
  logic [19:0]        ref16;
  logic signed [20:0] tdif;
  logic               in_trans;
  side_t              side3_next;
  logic [15:0]        off3_next;
  logic [11:0]        mul3_next;
  logic [15:0]        span3_next;
  logic [19:0]        mag3_next;
  logic [23:0]        tden3_next;

  always_comb begin
    seg = '0;
    for (int k = 1; k < PROF_N - 1; k++) begin
      if (d2 >= 24'(PROF_DEPTH[k] * 16)) seg = PROF_IW'(k);
    end
    deep     = d2 >= 24'(PROF_DEPTH[PROF_N-1] * 16);
    seg_lo   = 24'(PROF_DEPTH[seg] * 16);
    seg_drho = 16'(PROF_RHO[seg + PROF_IW'(1)] - PROF_RHO[seg]);
    fl16     = {fluid_rho, 4'b0};
    ref16    = {reference_density, 4'b0};
    tdif     = $signed({1'b0, ref16}) - $signed({1'b0, fl16});

    side3_next.valid   = v2;
    side3_next.t       = t2;
    side3_next.invalid = overpressure_enable & (transition_start_depth >= transition_end_depth);

    if (deep) begin
      side3_next.rock_base = 16'(PROF_RHO[PROF_N-1] * 16);
      side3_next.rock_neg  = 1'b0;
      off3_next            = '0;
      mul3_next            = '0;
      span3_next           = 16'd1;
    end else begin
      side3_next.rock_base = 16'(PROF_RHO[seg] * 16);
      side3_next.rock_neg  = seg_drho < 0;
      off3_next            = 16'(d2 - seg_lo);
      mul3_next            = seg_drho < 0 ? 12'(-seg_drho * 16) : 12'(seg_drho * 16);
      span3_next           = 16'(PROF_DEPTH[seg + PROF_IW'(1)] * 16 - PROF_DEPTH[seg] * 16);
    end

    in_trans = 1'b0;
    if (!overpressure_enable || d2 <= transition_start_depth) begin
      side3_next.pf_base = fl16;
    end else if (d2 <= transition_end_depth) begin
      side3_next.pf_base = fl16;
      in_trans           = 1'b1;
    end else begin
      side3_next.pf_base = ref16;
    end
    side3_next.trans_neg = tdif < 0;
    if (in_trans) begin
      mag3_next  = tdif < 0 ? 20'(-tdif) : 20'(tdif);
      tden3_next = transition_end_depth - transition_start_depth;
    end else begin
      mag3_next  = '0;
      tden3_next = 24'd1;
    end
  end

  side_t       side3;
  logic [15:0] off3;
  logic [11:0] mul3;
  logic [15:0] span3;
  logic [19:0] mag3;
  logic [23:0] dma3;
  logic [23:0] tden3;

  always_ff @(posedge clk) begin
    if (rst) begin
      side3 <= '0;
    end else begin
      side3 <= side3_next;
    end
  end

  always_ff @(posedge clk) begin
    off3  <= off3_next;
    mul3  <= mul3_next;
    span3 <= span3_next;
    mag3  <= mag3_next;
    dma3  <= d2 - transition_start_depth;
    tden3 <= tden3_next;
  end

  // stage 4: numerator products
  side_t       side4;
  logic [27:0] rnum4;
  logic [43:0] tnum4;
  logic [15:0] span4;
  logic [23:0] tden4;

  always_ff @(posedge clk) begin
    if (rst) begin
      side4 <= '0;
    end else begin
      side4 <= side3;
    end
  end

  always_ff @(posedge clk) begin
    rnum4 <= 28'(off3) * 28'(mul3);
    tnum4 <= 44'(dma3) * 44'(mag3);
    span4 <= span3;
    tden4 <= tden3;
  end

  // stage 5: add half divisor for round to nearest
  side_t            side5;
  logic [NUM_W-1:0] rnum5;
  logic [NUM_W-1:0] tnum5;
  logic [DEN_W-1:0] rden5;
  logic [DEN_W-1:0] tden5;

  always_ff @(posedge clk) begin
    if (rst) begin
      side5 <= '0;
    end else begin
      side5 <= side4;
    end
  end

  always_ff @(posedge clk) begin
    rnum5 <= NUM_W'(rnum4) + NUM_W'(span4 >> 1);
    tnum5 <= NUM_W'(tnum4) + NUM_W'(tden4 >> 1);
    rden5 <= DEN_W'(span4);
    tden5 <= tden4;
  end

  // dividers
  logic             rdv_valid;
  logic             tdv_valid;
  logic [QUO_W-1:0] rquo;
  logic [QUO_W-1:0] tquo;
  side_t            side_d;
  logic             tside_d;

  ddbf_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W), .SW($bits(side_t))) u_rock_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (side5.valid),
    .num      (rnum5),
    .den      (rden5),
    .side_in  (side5),
    .out_valid(rdv_valid),
    .quo      (rquo),
    .side_out (side_d)
  );

  ddbf_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W), .SW(1)) u_trans_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (side5.valid),
    .num      (tnum5),
    .den      (tden5),
    .side_in  (side5.trans_neg),
    .out_valid(tdv_valid),
    .quo      (tquo),
    .side_out (tside_d)
  );

  // post 1: density difference
  logic                     vp1;
  logic signed [DIFF_W-1:0] diff_p1;
  logic signed [15:0]       t_p1;
  logic                     inv_p1;
  logic signed [DIFF_W-1:0] rock;
  logic signed [DIFF_W-1:0] pf;

  always_comb begin
    rock = side_d.rock_neg ? $signed(DIFF_W'(side_d.rock_base)) - $signed(DIFF_W'(rquo))
                           : $signed(DIFF_W'(side_d.rock_base)) + $signed(DIFF_W'(rquo));
    pf   = tside_d ? $signed(DIFF_W'(side_d.pf_base)) - $signed(DIFF_W'(tquo))
                   : $signed(DIFF_W'(side_d.pf_base)) + $signed(DIFF_W'(tquo));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp1 <= 1'b0;
    end else begin
      vp1 <= rdv_valid & tdv_valid;
    end
  end

  always_ff @(posedge clk) begin
    diff_p1 <= rock - pf;
    t_p1    <= side_d.t;
    inv_p1  <= side_d.invalid;
  end

  // post 2: times gravity
  logic               vp2;
  logic signed [40:0] mg_p2;
  logic signed [15:0] t_p2;
  logic               inv_p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp2 <= 1'b0;
    end else begin
      vp2 <= vp1;
    end
  end

  always_ff @(posedge clk) begin
    mg_p2  <= 41'(diff_p1) * $signed({25'b0, gravity});
    t_p2   <= t_p1;
    inv_p2 <= inv_p1;
  end

  // post 3: times test value
  logic               vp3;
  logic signed [56:0] prod_p3;
  logic               inv_p3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp3 <= 1'b0;
    end else begin
      vp3 <= vp2;
    end
  end

  always_ff @(posedge clk) begin
    prod_p3 <= 57'(mg_p2) * 57'(t_p2);
    inv_p3  <= inv_p2;
  end

  // post 4: saturate to result width
  logic ovf;
  assign ovf = (prod_p3[56:RES_W-1] != '0) && (prod_p3[56:RES_W-1] != '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vp3;
    end
  end

  always_ff @(posedge clk) begin
    if (ovf) begin
      residual <= prod_p3[56] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end else begin
      residual <= prod_p3[RES_W-1:0];
    end
    config_invalid <= inv_p3;
  end

endmodule

>>> bench/ddbf_checker.sv
`timescale 1ns / 100ps

module ddbf_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [23:0] z_coordinate,
  input  logic signed [15:0] test_value,
  input  logic               done,
  input  logic signed [51:0] residual,
  input  logic               config_invalid,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import ddbf_pkg::*;

  typedef struct {
    logic signed [51:0] res;
    logic               inv;
  } force_t;

  force_t force_q[$];

  // shadow copy of the configuration
  logic [15:0] fluid_rho, grav, ref_rho;
  logic        op_en;
  logic [23:0] depth_a, depth_b;

  // round to nearest, ties away from zero
  function automatic longint rdiv(longint num, longint den);
    if (den <= 0) return 0;
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  // rock density in 1/16 kg/m^3 at a Q20.4 depth
  function automatic longint rock_q4(longint d);
    longint lo, hi;
    if (d <= longint'(PROF_DEPTH[0]) * 16) return longint'(PROF_RHO[0]) * 16;
    if (d >= longint'(PROF_DEPTH[PROF_N-1]) * 16) return longint'(PROF_RHO[PROF_N-1]) * 16;
    for (int i = 0; i + 1 < PROF_N; i++) begin
      lo = longint'(PROF_DEPTH[i]) * 16;
      hi = longint'(PROF_DEPTH[i+1]) * 16;
      if (d >= lo && d <= hi) begin
        if (hi - lo <= 0) return longint'(PROF_RHO[i]) * 16;
        return longint'(PROF_RHO[i]) * 16 +
               rdiv((d - lo) * (PROF_RHO[i+1] - PROF_RHO[i]) * 16, hi - lo);
      end
    end
    return longint'(PROF_RHO[PROF_N-1]) * 16;
  endfunction

  function automatic force_t body_force(logic signed [23:0] z, logic signed [15:0] t);
    force_t f;
    longint d, pf, fl, rf, a, b, prod;
    d = (z < 0) ? -longint'(z) : longint'(z);
    fl = longint'(fluid_rho) * 16;
    rf = longint'(ref_rho) * 16;
    a = depth_a;
    b = depth_b;
    f.inv = 1'b0;
    if (!op_en) begin
      pf = fl;
    end else begin
      f.inv = (a >= b);
      if (d <= a) pf = fl;
      else if (d <= b) pf = fl + rdiv((rf - fl) * (d - a), b - a);
      else pf = rf;
    end
    prod = (rock_q4(d) - pf) * longint'(grav) * longint'(t);
    if (prod > 64'sd2251799813685247) prod = 64'sd2251799813685247;
    if (prod < -64'sd2251799813685248) prod = -64'sd2251799813685248;
    f.res = prod[51:0];
    return f;
  endfunction

  assign pending = force_q.size();

  always @(posedge clk) begin
    force_t e;
    if (rst) begin
      fluid_rho <= 16'd1000;
      grav      <= 16'd40141;
      op_en     <= 1'b0;
      depth_a   <= '0;
      depth_b   <= '0;
      ref_rho   <= 16'd2900;
      force_q.delete();
      fail_count <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_FLUID_DENSITY: fluid_rho <= cfg_data[15:0];
          REG_GRAVITY:       grav      <= cfg_data[15:0];
          REG_OVERPRESSURE:  op_en     <= cfg_data[0];
          REG_TRANS_START:   depth_a   <= cfg_data;
          REG_TRANS_END:     depth_b   <= cfg_data;
          REG_REF_DENSITY:   ref_rho   <= cfg_data[15:0];
          default: ;
        endcase
      end
      // accepted request
      if (start && !busy) force_q.push_back(body_force(z_coordinate, test_value));
      // result compare
      if (done) begin
        if (force_q.size() == 0) begin
          $display("%0t: unexpected result residual=%0d invalid=%0b", $time, residual,
                   config_invalid);
          fail_count <= fail_count + 1;
        end else begin
          e = force_q.pop_front();
          if (e.res !== residual || e.inv !== config_invalid) begin
            $display("%0t: mismatch expected residual=%0d invalid=%0b actual residual=%0d invalid=%0b",
                     $time, e.res, e.inv, residual, config_invalid);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import ddbf_pkg::*;

  localparam int LATENCY = 29;
  localparam longint CYCLE_LIMIT = 400000;
  // index past the register list, writes are ignored
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [23:0] z_coordinate = '0;
  logic signed [15:0] test_value = '0;
  logic               done;
  logic signed [51:0] residual;
  logic               config_invalid;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;
  int                 fail_count;
  int                 pending;
  longint             cycles = 0;

  always #10 clk = ~clk;

  depth_density_body_force_residual_unit u_dut (.*);

  ddbf_checker u_chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("depth_density_body_force_residual_unit verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold one request until it is taken
  task automatic send_point(logic signed [23:0] z, logic signed [15:0] t);
    start        <= 1'b1;
    z_coordinate <= z;
    test_value   <= t;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    idle(1);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // depth near a profile knot or a transition edge, or at random, either sign
  function automatic logic signed [23:0] pick_z(logic [23:0] a, logic [23:0] b);
    logic [23:0] d;
    case ($urandom_range(0, 5))
      0: d = 24'($urandom());
      1: d = 24'(PROF_DEPTH[$urandom_range(0, PROF_N - 1)] * 16 + $urandom_range(0, 40) - 20);
      2: d = 24'(a + $urandom_range(0, 40) - 20);
      3: d = 24'(b + $urandom_range(0, 40) - 20);
      4: d = 24'($urandom_range(0, 15000 * 16 + 100));
      default: d = 24'(a + $urandom_range(0, 32'(b > a ? b - a : 24'd16)));
    endcase
    if (d[23]) d = 24'h7fffff & d;
    return $urandom_range(0, 1) ? -$signed(d) : $signed(d);
  endfunction

  task automatic random_phase(int n, logic [23:0] a, logic [23:0] b);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && n > 0; k++, n--)
        send_point(($urandom_range(0, 19) == 0) ? $signed(24'($urandom())) : pick_z(a, b),
                   16'($urandom()));
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 8));
    end
  endtask

  logic [23:0] ta, tb_d;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes and profile clamps at reset settings
    send_point(24'sh800000, 16'sh7fff);
    send_point(24'sh800000, 16'sh8000);
    send_point(24'sh7fffff, 16'sh7fff);
    send_point(24'sd0, 16'sh8000);
    send_point(24'sd0, 16'sd0);
    send_point(-24'sd8, 16'sd16384);
    send_point(24'sd8000, 16'sd16384);
    send_point(24'sd16000, -16'sd1);
    send_point(-24'sd240000, 16'sh7fff);
    send_point(24'sd240001, 16'sd1);
    drain();

    // overpressure with a valid transition
    write_reg(REG_OVERPRESSURE, 24'd1);
    write_reg(REG_TRANS_START, 24'd32000);
    write_reg(REG_TRANS_END, 24'd80000);
    send_point(24'sd32000, 16'sd16384);
    send_point(24'sd32001, 16'sd16384);
    send_point(-24'sd56000, 16'sd16384);
    send_point(24'sd80000, -16'sd16384);
    send_point(24'sd80001, 16'sd16384);
    drain();

    // invalid setup: equal and reversed edges
    write_reg(REG_TRANS_END, 24'd32000);
    send_point(24'sd32000, 16'sd100);
    send_point(24'sd32001, 16'sd100);
    drain();
    write_reg(REG_TRANS_END, 24'd0);
    send_point(24'sd5, 16'sd100);
    drain();

    // saturation: extreme densities and gravity
    write_reg(REG_FLUID_DENSITY, 24'd65535);
    write_reg(REG_GRAVITY, 24'd65535);
    write_reg(REG_REF_DENSITY, 24'd0);
    write_reg(REG_UNUSED, 24'hffffff);
    send_point(24'sd0, 16'sh8000);
    send_point(24'sd0, 16'sh7fff);
    send_point(24'sd400000, 16'sh8000);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin
          ta = 24'($urandom_range(0, 100000));
          tb_d = 24'(ta + $urandom_range(1, 200000));
        end
        1: begin
          ta = 24'($urandom_range(0, 300000));
          tb_d = 24'($urandom_range(0, 300000));
        end
        2: begin ta = 24'hffffff; tb_d = 24'd0; end
        default: begin ta = 24'd0; tb_d = 24'hffffff; end
      endcase
      write_reg(REG_OVERPRESSURE, 24'($urandom_range(0, 3) != 0));
      write_reg(REG_TRANS_START, ta);
      write_reg(REG_TRANS_END, tb_d);
      write_reg(REG_FLUID_DENSITY, (ph == 5) ? 24'd0 : 24'($urandom_range(0, 65535)));
      write_reg(REG_GRAVITY, (ph == 6) ? 24'd0 : 24'($urandom_range(0, 65535)));
      write_reg(REG_REF_DENSITY, (ph == 7) ? 24'd65535 : 24'($urandom_range(0, 65535)));
      if (ph % 3 == 0) begin
        write_reg(REG_FLUID_DENSITY, 24'($urandom_range(900, 1100)));
        write_reg(REG_REF_DENSITY, 24'($urandom_range(2500, 3000)));
      end
      random_phase(100, ta, tb_d);
      drain();
    end

    if (fail_count == 0)
      $display("depth_density_body_force_residual_unit verification clean");
    else
      $display("depth_density_body_force_residual_unit verification failed");
    $finish;
  end

endmodule
